// ----- hw/rtl/mmlp_pkg.sv -----
// Shared types and character codes for the memory-map line parser.
// No dependencies.
package mmlp_pkg;

  // Field being parsed within the current line
  typedef enum logic [3:0] {
    PhStart  = 4'd0,
    PhEnd    = 4'd1,
    PhR      = 4'd2,
    PhW      = 4'd3,
    PhX      = 4'd4,
    PhP      = 4'd5,
    PhSp     = 4'd6,
    PhOffset = 4'd7,
    PhMajor  = 4'd8,
    PhMinor  = 4'd9,
    PhInode  = 4'd10,
    PhSkip   = 4'd11
  } phase_e;

  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowF    = 8'h66;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;
  localparam logic [7:0] CharDash    = 8'h2d;
  localparam logic [7:0] CharColon   = 8'h3a;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0a;
  localparam logic [7:0] CharR       = 8'h72;
  localparam logic [7:0] CharW       = 8'h77;
  localparam logic [7:0] CharX       = 8'h78;
  localparam logic [7:0] CharP       = 8'h70;
  localparam logic [7:0] CharS       = 8'h73;

  // Permission bit positions in the saved flags
  localparam int unsigned PermRd = 0;
  localparam int unsigned PermWr = 1;
  localparam int unsigned PermEx = 2;
  localparam int unsigned PermPv = 3;

endpackage

// ----- hw/rtl/mmlp_digit_acc.sv -----
// Digit decode and saturating shift-add step for hex and decimal numbers.
// Depends on mmlp_pkg for character codes.
module mmlp_digit_acc #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [7:0]             text_byte_i,
  input  logic                   decimal_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  output logic                   is_digit_o,
  output logic [VALUE_WIDTH-1:0] acc_o
);

  localparam int unsigned ExtWidth = VALUE_WIDTH + 4;

  logic                is_dec;
  logic                is_lower;
  logic                is_upper;
  logic [3:0]          digit;
  logic                hex_ovf;
  logic [ExtWidth-1:0] acc_ext;
  logic [ExtWidth-1:0] dec_sum;
  logic                dec_ovf;

  assign is_dec   = (text_byte_i >= mmlp_pkg::CharZero) && (text_byte_i <= mmlp_pkg::CharNine);
  assign is_lower = (text_byte_i >= mmlp_pkg::CharLowA) && (text_byte_i <= mmlp_pkg::CharLowF);
  assign is_upper = (text_byte_i >= mmlp_pkg::CharUpA) && (text_byte_i <= mmlp_pkg::CharUpF);

  assign is_digit_o = is_dec || (!decimal_i && (is_lower || is_upper));

  // letters: low nibble of 'a'/'A' is 1, so add 9
  assign digit = is_dec ? text_byte_i[3:0] : 4'(text_byte_i[3:0] + 4'd9);

  // hex: x*16 overflows exactly when the top nibble is non-zero
  assign hex_ovf = |acc_i[VALUE_WIDTH-1 -: 4];

  // decimal: x*10 + d = x*8 + x*2 + d, checked in a widened sum
  assign acc_ext = ExtWidth'(acc_i);
  assign dec_sum = (acc_ext << 3) + (acc_ext << 1) + ExtWidth'(digit);
  assign dec_ovf = |dec_sum[ExtWidth-1 -: 4];

  always_comb begin
    if (decimal_i) begin
      acc_o = dec_ovf ? '1 : dec_sum[VALUE_WIDTH-1:0];
    end else begin
      acc_o = hex_ovf ? '1 : {acc_i[VALUE_WIDTH-5:0], digit};
    end
  end

endmodule

// ----- hw/rtl/memory_map_line_parser.sv -----
// Memory-map line parser: one text byte per transfer, one record per newline.
// Pipeline: a byte is registered on transfer and parsed from the input register; a
// newline's record is then loaded into the output register unless a record waits.
// Throughput: one byte per cycle; input stalls only while a record waits.
// Reset (rst_ni low, asynchronous): empty pipeline, parser at the start field.
// Depends on mmlp_pkg and mmlp_digit_acc.
module memory_map_line_parser #(
  parameter int unsigned VALUE_WIDTH  = 64,
  parameter int unsigned COLUMN_WIDTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  // record channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] range_start_o,
  output logic [63:0] range_end_o,
  output logic        readable_o,
  output logic        writable_o,
  output logic        executable_o,
  output logic        private_map_o,
  output logic [63:0] file_offset_o,
  output logic [31:0] dev_major_o,
  output logic [31:0] dev_minor_o,
  output logic [63:0] inode_number_o,
  output logic        status_o,
  output logic [11:0] error_column_o
);

  localparam logic [63:0] DevMax = 64'h0000_0000_FFFF_FFFF;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       advance;   // the held byte is consumed this cycle
  logic       in_xfer;

  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= text_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  mmlp_pkg::phase_e         phase_q, phase_d;
  logic [VALUE_WIDTH-1:0]   acc_q, acc_d;       // number in progress; inode once skipping
  logic                     digit_seen_q, digit_seen_d;
  logic [VALUE_WIDTH-1:0]   start_q, start_d;
  logic [VALUE_WIDTH-1:0]   end_q, end_d;
  logic [VALUE_WIDTH-1:0]   offset_q, offset_d;
  logic [31:0]              major_q, major_d;
  logic [31:0]              minor_q, minor_d;
  logic [3:0]               perm_q, perm_d;
  logic                     err_q, err_d;
  logic [COLUMN_WIDTH-1:0]  col_q, col_d;
  logic [COLUMN_WIDTH-1:0]  bad_col_q, bad_col_d;

  logic                     is_digit;
  logic [VALUE_WIDTH-1:0]   acc_step;
  logic                     is_newline;
  logic                     is_blank;
  logic [COLUMN_WIDTH-1:0]  col_inc;
  logic [7:0]               want;
  logic [31:0]              acc_dev;
  logic                     rec_load;
  logic                     rec_ok;
  logic [COLUMN_WIDTH-1:0]  rec_col;

  mmlp_digit_acc #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digit_acc (
    .text_byte_i(byte_q),
    .decimal_i  (phase_q == mmlp_pkg::PhInode),
    .acc_i      (acc_q),
    .is_digit_o (is_digit),
    .acc_o      (acc_step)
  );

  assign is_newline = (byte_q == mmlp_pkg::CharNewline);
  assign is_blank   = (byte_q == mmlp_pkg::CharSpace) || (byte_q == mmlp_pkg::CharTab);

  // saturating 1-based column of the held byte
  assign col_inc = (col_q != '1) ? col_q + 1'b1 : col_q;

  // device numbers saturate at 32 bits
  assign acc_dev = (64'(acc_q) > DevMax) ? '1 : 32'(64'(acc_q));

  // a newline stalls only when the previous record is still waiting
  assign advance  = !(is_newline && out_valid_o && out_stall_i);
  assign rec_load = in_valid_q && is_newline && advance;

  // newline before the inode is complete is itself the bad character
  assign rec_ok  = !err_q && ((phase_q == mmlp_pkg::PhInode) || (phase_q >= mmlp_pkg::PhSkip));
  assign rec_col = err_q ? bad_col_q : col_inc;

  always_comb begin
    case (phase_q)
      mmlp_pkg::PhStart: want = mmlp_pkg::CharDash;
      mmlp_pkg::PhMajor: want = mmlp_pkg::CharColon;
      default:           want = mmlp_pkg::CharSpace;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    digit_seen_d = digit_seen_q;
    start_d      = start_q;
    end_d        = end_q;
    offset_d     = offset_q;
    major_d      = major_q;
    minor_d      = minor_q;
    perm_d       = perm_q;
    err_d        = err_q;
    col_d        = col_q;
    bad_col_d    = bad_col_q;

    if (in_valid_q && advance) begin
      col_d = col_inc;
      if (is_newline) begin
        // record goes out; start the next line afresh
        phase_d      = mmlp_pkg::PhStart;
        acc_d        = '0;
        digit_seen_d = 1'b0;
        start_d      = '0;
        end_d        = '0;
        offset_d     = '0;
        major_d      = '0;
        minor_d      = '0;
        perm_d       = '0;
        err_d        = 1'b0;
        col_d        = '0;
        bad_col_d    = '0;
      end else if (!err_q) begin
        case (phase_q)
          mmlp_pkg::PhStart, mmlp_pkg::PhEnd, mmlp_pkg::PhOffset,
          mmlp_pkg::PhMajor, mmlp_pkg::PhMinor, mmlp_pkg::PhInode: begin
            if (is_digit) begin
              acc_d        = acc_step;
              digit_seen_d = 1'b1;
            end else if (!digit_seen_q && is_blank) begin
              // leading blank, skipped
            end else if (byte_q != want) begin
              err_d     = 1'b1;
              bad_col_d = col_inc;
              phase_d   = mmlp_pkg::PhSkip;
            end else begin
              acc_d        = '0;
              digit_seen_d = 1'b0;
              case (phase_q)
                mmlp_pkg::PhStart: begin
                  start_d = acc_q;
                  phase_d = mmlp_pkg::PhEnd;
                end
                mmlp_pkg::PhEnd: begin
                  end_d   = acc_q;
                  phase_d = mmlp_pkg::PhR;
                end
                mmlp_pkg::PhOffset: begin
                  offset_d = acc_q;
                  phase_d  = mmlp_pkg::PhMajor;
                end
                mmlp_pkg::PhMajor: begin
                  major_d = acc_dev;
                  phase_d = mmlp_pkg::PhMinor;
                end
                mmlp_pkg::PhMinor: begin
                  minor_d = acc_dev;
                  phase_d = mmlp_pkg::PhInode;
                end
                default: begin
                  // inode done: hold it while the path is skipped
                  acc_d   = acc_q;
                  phase_d = mmlp_pkg::PhSkip;
                end
              endcase
            end
          end
          mmlp_pkg::PhR: begin
            if (byte_q == mmlp_pkg::CharR) begin
              perm_d[mmlp_pkg::PermRd] = 1'b1;
              phase_d = mmlp_pkg::PhW;
            end else if (byte_q == mmlp_pkg::CharDash) begin
              phase_d = mmlp_pkg::PhW;
            end else begin
              err_d     = 1'b1;
              bad_col_d = col_inc;
              phase_d   = mmlp_pkg::PhSkip;
            end
          end
          mmlp_pkg::PhW: begin
            if (byte_q == mmlp_pkg::CharW) begin
              perm_d[mmlp_pkg::PermWr] = 1'b1;
              phase_d = mmlp_pkg::PhX;
            end else if (byte_q == mmlp_pkg::CharDash) begin
              phase_d = mmlp_pkg::PhX;
            end else begin
              err_d     = 1'b1;
              bad_col_d = col_inc;
              phase_d   = mmlp_pkg::PhSkip;
            end
          end
          mmlp_pkg::PhX: begin
            if (byte_q == mmlp_pkg::CharX) begin
              perm_d[mmlp_pkg::PermEx] = 1'b1;
              phase_d = mmlp_pkg::PhP;
            end else if (byte_q == mmlp_pkg::CharDash) begin
              phase_d = mmlp_pkg::PhP;
            end else begin
              err_d     = 1'b1;
              bad_col_d = col_inc;
              phase_d   = mmlp_pkg::PhSkip;
            end
          end
          mmlp_pkg::PhP: begin
            if (byte_q == mmlp_pkg::CharP) begin
              perm_d[mmlp_pkg::PermPv] = 1'b1;
              phase_d = mmlp_pkg::PhSp;
            end else if (byte_q == mmlp_pkg::CharS) begin
              phase_d = mmlp_pkg::PhSp;
            end else begin
              err_d     = 1'b1;
              bad_col_d = col_inc;
              phase_d   = mmlp_pkg::PhSkip;
            end
          end
          mmlp_pkg::PhSp: begin
            if (byte_q == mmlp_pkg::CharSpace) begin
              phase_d = mmlp_pkg::PhOffset;
            end else begin
              err_d     = 1'b1;
              bad_col_d = col_inc;
              phase_d   = mmlp_pkg::PhSkip;
            end
          end
          default: begin
            // path text: ignored up to the newline
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mmlp_pkg::PhStart;
      acc_q        <= '0;
      digit_seen_q <= 1'b0;
      start_q      <= '0;
      end_q        <= '0;
      offset_q     <= '0;
      major_q      <= '0;
      minor_q      <= '0;
      perm_q       <= '0;
      err_q        <= 1'b0;
      col_q        <= '0;
      bad_col_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      digit_seen_q <= digit_seen_d;
      start_q      <= start_d;
      end_q        <= end_d;
      offset_q     <= offset_d;
      major_q      <= major_d;
      minor_q      <= minor_d;
      perm_q       <= perm_d;
      err_q        <= err_d;
      col_q        <= col_d;
      bad_col_q    <= bad_col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: an error record carries only status and column
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_load) begin
      range_start_o  <= rec_ok ? 64'(start_q) : '0;
      range_end_o    <= rec_ok ? 64'(end_q) : '0;
      readable_o     <= rec_ok && perm_q[mmlp_pkg::PermRd];
      writable_o     <= rec_ok && perm_q[mmlp_pkg::PermWr];
      executable_o   <= rec_ok && perm_q[mmlp_pkg::PermEx];
      private_map_o  <= rec_ok && perm_q[mmlp_pkg::PermPv];
      file_offset_o  <= rec_ok ? 64'(offset_q) : '0;
      dev_major_o    <= rec_ok ? major_q : '0;
      dev_minor_o    <= rec_ok ? minor_q : '0;
      inode_number_o <= rec_ok ? 64'(acc_q) : '0;
      status_o       <= !rec_ok;
      error_column_o <= rec_ok ? '0 : 12'(rec_col);
    end
  end

endmodule
